// ===== rtl/mvna_pkg.sv =====
// ============================================================================
// mvna_pkg
// Shared types and constants for the vertex normal accumulator: request
// codes, controller commands and datapath status.
// ============================================================================
package mvna_pkg;

    localparam int IDX_W = 12;
    localparam int POS_W = 16;
    localparam int VCNT_W = 13;
    localparam int ACC_W = 48;
    localparam int NRM_W = 16;

    localparam logic [VCNT_W-1:0] VCOUNT_RESET = 13'd4096;

    typedef enum logic [1:0] {
        REQ_POS_WRITE   = 2'd0,
        REQ_TRIANGLE    = 2'd1,
        REQ_READ_NORMAL = 2'd2,
        REQ_UNUSED      = 2'd3
    } req_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_CLEAR,
        OP_POS_WRITE,
        OP_POS_READ,
        OP_EDGE,
        OP_CROSS,
        OP_ACC_READ,
        OP_ACC_WRITE,
        OP_NRM_LOAD,
        OP_SHIFT_LEFT,
        OP_SHIFT_RIGHT,
        OP_SQUARE,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_WRITE,
        OP_OUT_LOAD
    } op_t;

    // Corner / component select; SEL_VERTEX addresses the request's vertex
    typedef enum logic [1:0] {
        SEL_A      = 2'd0,
        SEL_B      = 2'd1,
        SEL_C      = 2'd2,
        SEL_VERTEX = 2'd3
    } sel_t;

    typedef struct packed {
        op_t  op;
        sel_t sel;
        logic cap_en;
        sel_t cap_sel;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic bad;
        logic nrm_zero;
        logic nrm_low;
        logic nrm_high;
        logic clr_last;
    } sts_t;

endpackage

// ===== rtl/mesh_vertex_normal_accumulator.sv =====
// Throughput: one request at a time, set by the separate accumulator read and
//   write steps on triangles and by the bit-serial square root and divider on reads.
// Reset: a clearing pass over every entry zeroes the accumulators, in_ready low.
// ============================================================================
// mesh_vertex_normal_accumulator
// Area-weighted smooth vertex normals: stores Q8.8 vertex positions,
// accumulates triangle cross products per corner, returns Q1.14 normals.
// ============================================================================
module mesh_vertex_normal_accumulator
    import mvna_pkg::*;
#(
    parameter int MAX_VERTICES = 4096
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration: vertex count
    input  logic                    cfg_wr_en,
    input  logic [VCNT_W-1:0]       cfg_wr_data,
    // request channel
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              req_type,
    input  logic [IDX_W-1:0]        vertex_index,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic [IDX_W-1:0]        corner_a,
    input  logic [IDX_W-1:0]        corner_b,
    input  logic [IDX_W-1:0]        corner_c,
    // result channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    status,
    output logic signed [NRM_W-1:0] normal_x,
    output logic signed [NRM_W-1:0] normal_y,
    output logic signed [NRM_W-1:0] normal_z
);

    // Controller drives one command per cycle; datapath reports flags back.
    cmd_t cmd;
    sts_t sts;

    mvna_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The output register sits in the datapath: a finished result waits
    // there while the next request is transferred in and processed.
    mvna_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .req_type     (req_type),
        .vertex_index (vertex_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .cmd          (cmd),
        .sts          (sts),
        .status       (status),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z)
    );

endmodule

// ===== rtl/mvna_dp.sv =====
// ============================================================================
// mvna_dp
// Datapath: position and accumulator memories, cross product, saturating
// accumulate, and the shift / square-root / divide normalizer.
// ============================================================================
module mvna_dp
    import mvna_pkg::*;
#(
    parameter int MAX_VERTICES = 4096
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [VCNT_W-1:0]       cfg_wr_data,
    input  logic [1:0]              req_type,
    input  logic [IDX_W-1:0]        vertex_index,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic [IDX_W-1:0]        corner_a,
    input  logic [IDX_W-1:0]        corner_b,
    input  logic [IDX_W-1:0]        corner_c,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    output logic                    status,
    output logic signed [NRM_W-1:0] normal_x,
    output logic signed [NRM_W-1:0] normal_y,
    output logic signed [NRM_W-1:0] normal_z
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam logic [16:0] MAX_V = 17'(MAX_VERTICES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    function automatic logic idx_ok(logic [IDX_W-1:0] idx, logic [VCNT_W-1:0] vc);
        return ({1'b0, idx} < vc) && ({5'b0, idx} < MAX_V);
    endfunction

    function automatic logic [AW-1:0] addr_of(logic [IDX_W-1:0] idx);
        logic [16:0] ext;
        ext = {5'b0, idx};
        return ext[AW-1:0];
    endfunction

    function automatic logic [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
                                                 logic signed [34:0] d);
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(d);
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

    // Control registers
    logic [VCNT_W-1:0] vcount_reg;
    logic [AW-1:0]     clr_addr_reg;

    // Latched request
    req_t              req_reg;
    logic              bad_reg;
    logic [IDX_W-1:0]  vidx_reg;
    logic [IDX_W-1:0]  cidx_reg [3];
    logic [3*POS_W-1:0] wpos_reg;

    // Triangle path
    logic [3*POS_W-1:0] pos_rdata_reg;
    logic [3*POS_W-1:0] corner_reg [3];
    logic signed [16:0] e1_reg [3];
    logic signed [16:0] e2_reg [3];
    logic signed [34:0] n_reg [3];
    logic [3*ACC_W-1:0] acc_rdata_reg;

    // Normalizer
    logic [ACC_W-1:0]  mag_reg [3];
    logic              neg_reg [3];
    logic [63:0]       sum_reg;
    logic [63:0]       v_reg;
    logic [63:0]       r_reg;
    logic [63:0]       bit_reg;
    logic [49:0]       rem_reg;
    logic [49:0]       ds_reg;
    logic [NRM_W-1:0]  q_reg;

    // Results
    logic              res_status_reg;
    logic [NRM_W-1:0]  res_n_reg [3];
    logic              out_status_reg;
    logic [NRM_W-1:0]  out_n_reg [3];

    logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
    logic [3*ACC_W-1:0] acc_mem [MAX_VERTICES];

    logic [1:0]         csel;
    logic [AW-1:0]      sel_addr;
    logic               latch_bad;
    logic signed [16:0] mop0, mop1, mop2, mop3;
    logic signed [33:0] prod0, prod1;
    logic signed [34:0] cross_val;
    logic [61:0]        square;
    logic [63:0]        sq_t;
    logic               acc_we;
    logic [AW-1:0]      acc_waddr;
    logic [3*ACC_W-1:0] acc_wdata;
    logic [ACC_W-1:0]   neg_c [3];

    assign csel = cmd.sel;

    always_comb
    begin
        case (cmd.sel)
            SEL_A:   sel_addr = addr_of(cidx_reg[0]);
            SEL_B:   sel_addr = addr_of(cidx_reg[1]);
            SEL_C:   sel_addr = addr_of(cidx_reg[2]);
            default: sel_addr = addr_of(vidx_reg);
        endcase
    end

    always_comb
    begin
        case (req_t'(req_type))
            REQ_POS_WRITE, REQ_READ_NORMAL: latch_bad = !idx_ok(vertex_index, vcount_reg);
            REQ_TRIANGLE: latch_bad = !(idx_ok(corner_a, vcount_reg)
                                        && idx_ok(corner_b, vcount_reg)
                                        && idx_ok(corner_c, vcount_reg));
            default: latch_bad = 1'b0;
        endcase
    end

    // Cross product: one component per cycle, two multiplies
    always_comb
    begin
        case (cmd.sel)
            SEL_A:
            begin
                mop0 = e1_reg[1]; mop1 = e2_reg[2]; mop2 = e1_reg[2]; mop3 = e2_reg[1];
            end
            SEL_B:
            begin
                mop0 = e1_reg[2]; mop1 = e2_reg[0]; mop2 = e1_reg[0]; mop3 = e2_reg[2];
            end
            default:
            begin
                mop0 = e1_reg[0]; mop1 = e2_reg[1]; mop2 = e1_reg[1]; mop3 = e2_reg[0];
            end
        endcase
        prod0 = mop0 * mop1;
        prod1 = mop2 * mop3;
        cross_val = 35'(prod0) - 35'(prod1);
    end

    assign square = mag_reg[csel][30:0] * mag_reg[csel][30:0];
    assign sq_t   = r_reg + bit_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            neg_c[k] = -acc_rdata_reg[k*ACC_W +: ACC_W];
    end

    always_comb
    begin
        acc_we    = 1'b0;
        acc_waddr = sel_addr;
        acc_wdata = '0;
        case (cmd.op)
            OP_CLEAR:
            begin
                acc_we    = 1'b1;
                acc_waddr = clr_addr_reg;
            end
            OP_POS_WRITE:
            begin
                acc_we = 1'b1;
            end
            OP_ACC_WRITE:
            begin
                acc_we = 1'b1;
                for (int k = 0; k < 3; k++)
                    acc_wdata[k*ACC_W +: ACC_W] =
                        sat_add(acc_rdata_reg[k*ACC_W +: ACC_W], n_reg[k]);
            end
            default:
            begin
                acc_we = 1'b0;
            end
        endcase
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_POS_WRITE)
            pos_mem[sel_addr] <= wpos_reg;
        if (cmd.op == OP_POS_READ)
            pos_rdata_reg <= pos_mem[sel_addr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[acc_waddr] <= acc_wdata;
        if (cmd.op == OP_ACC_READ)
            acc_rdata_reg <= acc_mem[sel_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg   <= VCOUNT_RESET;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                vcount_reg <= cfg_wr_data;
            if (cmd.op == OP_CLEAR)
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
            corner_reg[cmd.cap_sel] <= pos_rdata_reg;
        case (cmd.op)
            OP_LATCH:
            begin
                req_reg        <= req_t'(req_type);
                bad_reg        <= latch_bad;
                vidx_reg       <= vertex_index;
                cidx_reg[0]    <= corner_a;
                cidx_reg[1]    <= corner_b;
                cidx_reg[2]    <= corner_c;
                wpos_reg       <= {pos_z, pos_y, pos_x};
                res_status_reg <= latch_bad;
                for (int k = 0; k < 3; k++)
                    res_n_reg[k] <= '0;
            end
            OP_EDGE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e1_reg[k] <= {corner_reg[1][k*POS_W+POS_W-1], corner_reg[1][k*POS_W +: POS_W]}
                               - {corner_reg[0][k*POS_W+POS_W-1], corner_reg[0][k*POS_W +: POS_W]};
                    e2_reg[k] <= {corner_reg[2][k*POS_W+POS_W-1], corner_reg[2][k*POS_W +: POS_W]}
                               - {corner_reg[0][k*POS_W+POS_W-1], corner_reg[0][k*POS_W +: POS_W]};
                end
            end
            OP_CROSS:
            begin
                n_reg[csel] <= cross_val;
            end
            OP_NRM_LOAD:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    neg_reg[k] <= acc_rdata_reg[k*ACC_W + ACC_W - 1];
                    mag_reg[k] <= acc_rdata_reg[k*ACC_W + ACC_W - 1]
                                ? neg_c[k] : acc_rdata_reg[k*ACC_W +: ACC_W];
                end
                sum_reg <= '0;
            end
            OP_SHIFT_LEFT:
            begin
                for (int k = 0; k < 3; k++)
                    mag_reg[k] <= {mag_reg[k][ACC_W-2:0], 1'b0};
            end
            OP_SHIFT_RIGHT:
            begin
                for (int k = 0; k < 3; k++)
                    mag_reg[k] <= {1'b0, mag_reg[k][ACC_W-1:1]};
            end
            OP_SQUARE:
            begin
                sum_reg <= sum_reg + 64'(square);
            end
            OP_SQRT_INIT:
            begin
                v_reg   <= sum_reg;
                r_reg   <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
            OP_SQRT_STEP:
            begin
                if (v_reg >= sq_t)
                begin
                    v_reg <= v_reg - sq_t;
                    r_reg <= {1'b0, r_reg[63:1]} + bit_reg;
                end
                else
                begin
                    r_reg <= {1'b0, r_reg[63:1]};
                end
                bit_reg <= {2'b0, bit_reg[63:2]};
            end
            OP_DIV_INIT:
            begin
                rem_reg <= ({19'b0, mag_reg[csel][30:0]} << 15) + {17'b0, r_reg[32:0]};
                ds_reg  <= {17'b0, r_reg[32:0]} << 16;
                q_reg   <= '0;
            end
            OP_DIV_STEP:
            begin
                if (rem_reg >= ds_reg)
                begin
                    rem_reg <= rem_reg - ds_reg;
                    q_reg   <= {q_reg[NRM_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[NRM_W-2:0], 1'b0};
                end
                ds_reg <= {1'b0, ds_reg[49:1]};
            end
            OP_DIV_WRITE:
            begin
                res_n_reg[csel] <= neg_reg[csel] ? -q_reg : q_reg;
            end
            OP_OUT_LOAD:
            begin
                out_status_reg <= res_status_reg;
                for (int k = 0; k < 3; k++)
                    out_n_reg[k] <= res_n_reg[k];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        sts.req      = req_reg;
        sts.bad      = bad_reg;
        sts.nrm_zero = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);
        sts.nrm_low  = (mag_reg[0][ACC_W-1:30] == '0) && (mag_reg[1][ACC_W-1:30] == '0)
                       && (mag_reg[2][ACC_W-1:30] == '0);
        sts.nrm_high = (mag_reg[0][ACC_W-1:31] != '0) || (mag_reg[1][ACC_W-1:31] != '0)
                       || (mag_reg[2][ACC_W-1:31] != '0);
        sts.clr_last = (clr_addr_reg == LAST_ADDR);
    end

    assign status   = out_status_reg;
    assign normal_x = out_n_reg[0];
    assign normal_y = out_n_reg[1];
    assign normal_z = out_n_reg[2];

endmodule

// ===== rtl/mvna_ctrl.sv =====
// ============================================================================
// mvna_ctrl
// Controller: sequences the datapath for each request and owns the
// input/output handshakes.
// ============================================================================
module mvna_ctrl
    import mvna_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_POS_WRITE,
        S_TRI_RA,
        S_TRI_RB,
        S_TRI_RC,
        S_TRI_CAP,
        S_TRI_EDGE,
        S_TRI_CROSS,
        S_TRI_ARD,
        S_TRI_AWR,
        S_RD_ACC,
        S_NRM_LOAD,
        S_NRM_NORM,
        S_NRM_SQ,
        S_SQRT_INIT,
        S_SQRT_STEP,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_WRITE,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;
    logic       out_valid_reg, out_valid_next;
    sel_t       comp_sel;

    assign comp_sel = sel_t'(comp_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        comp_next      = comp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '{op: OP_NOP, sel: comp_sel, cap_en: 1'b0, cap_sel: SEL_A};

        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                comp_next = 2'd0;
                cnt_next  = '0;
                if (sts.bad)
                    state_next = S_FINISH;
                else
                begin
                    case (sts.req)
                        REQ_POS_WRITE:   state_next = S_POS_WRITE;
                        REQ_TRIANGLE:    state_next = S_TRI_RA;
                        REQ_READ_NORMAL: state_next = S_RD_ACC;
                        default:         state_next = S_FINISH;
                    endcase
                end
            end
            S_POS_WRITE:
            begin
                cmd.op     = OP_POS_WRITE;
                cmd.sel    = SEL_VERTEX;
                state_next = S_FINISH;
            end
            S_TRI_RA:
            begin
                cmd.op     = OP_POS_READ;
                cmd.sel    = SEL_A;
                state_next = S_TRI_RB;
            end
            S_TRI_RB:
            begin
                cmd.op      = OP_POS_READ;
                cmd.sel     = SEL_B;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = SEL_A;
                state_next  = S_TRI_RC;
            end
            S_TRI_RC:
            begin
                cmd.op      = OP_POS_READ;
                cmd.sel     = SEL_C;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = SEL_B;
                state_next  = S_TRI_CAP;
            end
            S_TRI_CAP:
            begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = SEL_C;
                state_next  = S_TRI_EDGE;
            end
            S_TRI_EDGE:
            begin
                cmd.op     = OP_EDGE;
                state_next = S_TRI_CROSS;
            end
            S_TRI_CROSS:
            begin
                cmd.op = OP_CROSS;
                if (comp_reg == 2'd2)
                begin
                    comp_next  = 2'd0;
                    state_next = S_TRI_ARD;
                end
                else
                    comp_next = comp_reg + 2'd1;
            end
            S_TRI_ARD:
            begin
                // read this corner; written back next cycle so a repeated
                // corner sees the previous update
                cmd.op     = OP_ACC_READ;
                state_next = S_TRI_AWR;
            end
            S_TRI_AWR:
            begin
                cmd.op = OP_ACC_WRITE;
                if (comp_reg == 2'd2)
                    state_next = S_FINISH;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_TRI_ARD;
                end
            end
            S_RD_ACC:
            begin
                cmd.op     = OP_ACC_READ;
                cmd.sel    = SEL_VERTEX;
                state_next = S_NRM_LOAD;
            end
            S_NRM_LOAD:
            begin
                cmd.op     = OP_NRM_LOAD;
                state_next = S_NRM_NORM;
            end
            S_NRM_NORM:
            begin
                if (sts.nrm_zero)
                    state_next = S_FINISH;
                else if (sts.nrm_low)
                    cmd.op = OP_SHIFT_LEFT;
                else if (sts.nrm_high)
                    cmd.op = OP_SHIFT_RIGHT;
                else
                    state_next = S_NRM_SQ;
            end
            S_NRM_SQ:
            begin
                cmd.op = OP_SQUARE;
                if (comp_reg == 2'd2)
                begin
                    comp_next  = 2'd0;
                    state_next = S_SQRT_INIT;
                end
                else
                    comp_next = comp_reg + 2'd1;
            end
            S_SQRT_INIT:
            begin
                cmd.op     = OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = S_SQRT_STEP;
            end
            S_SQRT_STEP:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                    state_next = S_DIV_WRITE;
            end
            S_DIV_WRITE:
            begin
                cmd.op = OP_DIV_WRITE;
                if (comp_reg == 2'd2)
                    state_next = S_FINISH;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_DIV_INIT;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/mvna_checker.sv =====
// ============================================================================
// mvna_checker
// Port-level checks on the result channel of the vertex normal accumulator.
// ============================================================================
module mvna_checker
    import mvna_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    status,
    input logic signed [NRM_W-1:0] normal_x,
    input logic signed [NRM_W-1:0] normal_y,
    input logic signed [NRM_W-1:0] normal_z
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(normal_x) && $stable(normal_y)
                                    && $stable(normal_z) && $stable(status))
        else $error("result changed while stalled");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
        else $error("rejected request carries a normal");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> normal_x >= -16384 && normal_x <= 16384
                      && normal_y >= -16384 && normal_y <= 16384
                      && normal_z >= -16384 && normal_z <= 16384)
        else $error("normal component outside unit range");

endmodule

bind mesh_vertex_normal_accumulator mvna_checker u_mvna_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .normal_z  (normal_z)
);
